### design/penalty_contact_force_with_friction_defines.svh
// assertion macros for the contact force block
`ifndef PENALTY_CONTACT_FORCE_WITH_FRICTION_DEFINES_SVH
`define PENALTY_CONTACT_FORCE_WITH_FRICTION_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define PCF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define PCF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/pcf_pkg.sv
`default_nettype none

package pcf_pkg;

  localparam int NODE_BITS_DEF = 24;
  localparam int NODE_FIELD_W  = 24;

  localparam int PEN_W  = 32;
  localparam int NRM_W  = 16;
  localparam int VEL_W  = 32;
  localparam int FN_W   = 50;
  localparam int VT_W   = 32;
  localparam int LIM_W  = 51;
  localparam int SS_W   = 64;
  localparam int VM_W   = 32;
  localparam int FMAG_W = 47;
  localparam int Q_W    = 15;
  localparam int NUM_W  = VT_W + Q_W - 1;
  localparam int FT_W   = 49;
  localparam int FRC_W  = 48;

  localparam int IN_W  = 200;
  localparam int OUT_W = 176;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [31:0]       PF_RESET    = 32'd65536;
  localparam logic [19:0]       STIFF_SCALE = 20'd1000000;
  localparam logic [6:0]        FRIC_SCALE  = 7'd100;
  localparam logic [FMAG_W-1:0] FORCE_MAX   = {FMAG_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PENALTY  = 2'd0,
    REG_FRICTION = 2'd1,
    REG_ENABLE   = 2'd2
  } reg_idx_t;

endpackage

`default_nettype wire

### design/pcf_sqrt.sv
`default_nettype none

module pcf_sqrt #(
  parameter int PW = 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      adv,
  input  logic                      in_valid,
  input  logic [pcf_pkg::SS_W-1:0]  radicand,
  input  logic [PW-1:0]             in_pl,
  output logic                      out_valid,
  output logic [pcf_pkg::VM_W-1:0]  root,
  output logic [PW-1:0]             out_pl
);
  import pcf_pkg::*;

  localparam int STEPS = VM_W;
  localparam int RW    = VM_W + 2;
  localparam int CW    = RW + 2;

  logic            vld_q [STEPS];
  logic [SS_W-1:0] x_q   [STEPS];
  logic [RW-1:0]   rem_q [STEPS];
  logic [VM_W-1:0] r_q   [STEPS];
  logic [PW-1:0]   pl_q  [STEPS];

  logic [SS_W-1:0] x_n   [STEPS];
  logic [RW-1:0]   rem_n [STEPS];
  logic [VM_W-1:0] r_n   [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic [SS_W-1:0] x_in;
    logic [RW-1:0]   rem_in;
    logic [VM_W-1:0] r_in;
    logic [CW-1:0]   cur;
    logic [CW-1:0]   trial;
    logic [CW-1:0]   diff;
    logic            take;

    if (k == 0) begin : g_first
      assign x_in   = radicand;
      assign rem_in = '0;
      assign r_in   = '0;
    end else begin : g_next
      assign x_in   = x_q[k-1];
      assign rem_in = rem_q[k-1];
      assign r_in   = r_q[k-1];
    end

    // one result bit per stage
    assign cur      = {rem_in, x_in[SS_W-1 -: 2]};
    assign trial    = {2'b00, r_in, 2'b01};
    assign take     = cur >= trial;
    assign diff     = cur - trial;
    assign rem_n[k] = take ? diff[RW-1:0] : cur[RW-1:0];
    assign r_n[k]   = {r_in[VM_W-2:0], take};
    assign x_n[k]   = x_in << 2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < STEPS; k++) vld_q[k] <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= in_valid;
      for (int k = 1; k < STEPS; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_q     <= x_n;
      rem_q   <= rem_n;
      r_q     <= r_n;
      pl_q[0] <= in_pl;
      for (int k = 1; k < STEPS; k++) pl_q[k] <= pl_q[k-1];
    end
  end

  assign out_valid = vld_q[STEPS-1];
  assign root      = r_q[STEPS-1];
  assign out_pl    = pl_q[STEPS-1];

endmodule

`default_nettype wire

### design/pcf_div.sv
`default_nettype none

module pcf_div #(
  parameter int PW = 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      adv,
  input  logic                      in_valid,
  input  logic [pcf_pkg::VT_W-1:0]  num [3],
  input  logic [pcf_pkg::VM_W-1:0]  den,
  input  logic [PW-1:0]             in_pl,
  output logic                      out_valid,
  output logic [pcf_pkg::Q_W-1:0]   quo [3],
  output logic [PW-1:0]             out_pl
);
  import pcf_pkg::*;

  localparam int CW = NUM_W + 1;

  logic             vld_q [Q_W];
  logic [NUM_W-1:0] rem_q [Q_W][3];
  logic [Q_W-1:0]   q_q   [Q_W][3];
  logic [VM_W-1:0]  den_q [Q_W];
  logic [PW-1:0]    pl_q  [Q_W];

  logic [NUM_W-1:0] rem_n [Q_W][3];
  logic [Q_W-1:0]   q_n   [Q_W][3];

  for (genvar k = 0; k < Q_W; k++) begin : g_step
    logic [NUM_W-1:0] rem_in [3];
    logic [Q_W-1:0]   q_in   [3];
    logic [VM_W-1:0]  den_in;
    logic [CW-1:0]    dsh;

    if (k == 0) begin : g_first
      assign den_in = den;
      for (genvar l = 0; l < 3; l++) begin : g_lane
        assign rem_in[l] = {num[l], {(Q_W-1){1'b0}}};
        assign q_in[l]   = '0;
      end
    end else begin : g_next
      assign den_in = den_q[k-1];
      for (genvar l = 0; l < 3; l++) begin : g_lane
        assign rem_in[l] = rem_q[k-1][l];
        assign q_in[l]   = q_q[k-1][l];
      end
    end

    // restoring step, quotient msb first
    assign dsh = CW'(den_in) << (Q_W - 1 - k);

    for (genvar l = 0; l < 3; l++) begin : g_calc
      logic          take;
      logic [CW-1:0] diff;
      assign take        = CW'(rem_in[l]) >= dsh;
      assign diff        = CW'(rem_in[l]) - dsh;
      assign rem_n[k][l] = take ? diff[NUM_W-1:0] : rem_in[l];
      assign q_n[k][l]   = {q_in[l][Q_W-2:0], take};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < Q_W; k++) vld_q[k] <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= in_valid;
      for (int k = 1; k < Q_W; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_q    <= rem_n;
      q_q      <= q_n;
      den_q[0] <= den;
      pl_q[0]  <= in_pl;
      for (int k = 1; k < Q_W; k++) begin
        den_q[k] <= den_q[k-1];
        pl_q[k]  <= pl_q[k-1];
      end
    end
  end

  assign out_valid = vld_q[Q_W-1];
  assign quo       = q_q[Q_W-1];
  assign out_pl    = pl_q[Q_W-1];

endmodule

`default_nettype wire

### design/penalty_contact_force_with_friction.sv
`default_nettype none

// Penalty contact force with Coulomb friction. Each transfer on the s_ side is one contact
// pair; exactly one result per pair leaves on the m_ side, in order. One pair is taken
// every cycle while m_ is not stalled; the pipeline is 57 register stages deep, most of it
// the 32-stage square root of the tangential speed and the 15-stage divider that forms the
// tangent direction. A stall on m_ freezes the whole pipe and drops s_tready. Registers are
// written over the cfg_ port (always ready) and are read directly by the pipe, so they may
// only change while no pair is in flight.
module penalty_contact_force_with_friction #(
  parameter int NODE_BITS = pcf_pkg::NODE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // node_index, penetration, normal_x, normal_y, normal_z, vel_x, vel_y, vel_z
  input  logic [pcf_pkg::IN_W-1:0]        s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // node_out, force_x, force_y, force_z, clipped, zero fill
  output logic [pcf_pkg::OUT_W-1:0]       m_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pcf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pcf_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import pcf_pkg::*;

  localparam int NODE_W = (NODE_BITS < NODE_FIELD_W) ? NODE_BITS : NODE_FIELD_W;
  localparam int SQ_PW  = NODE_W + 3*FN_W + 3*VT_W + LIM_W + 2;
  localparam int DV_PW  = NODE_W + 3*FN_W + 3 + FMAG_W + 1;

  logic [31:0] penalty_factor;
  logic [15:0] friction_coeff;
  logic        friction_enable;
  logic        adv;

  assign cfg_ready = 1'b1;
  assign adv       = !m_tvalid || m_tready;
  assign s_tready  = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      penalty_factor  <= PF_RESET;
      friction_coeff  <= '0;
      friction_enable <= 1'b0;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_PENALTY:  penalty_factor  <= cfg_data;
        REG_FRICTION: friction_coeff  <= cfg_data[15:0];
        REG_ENABLE:   friction_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input unpack
  logic [NODE_W-1:0]       in_node;
  logic signed [PEN_W-1:0] in_pen;
  logic signed [NRM_W-1:0] in_n [3];
  logic signed [VEL_W-1:0] in_v [3];

  assign in_node = s_tdata[NODE_W-1:0];
  assign in_pen  = s_tdata[55:24];
  assign in_n[0] = s_tdata[71:56];
  assign in_n[1] = s_tdata[87:72];
  assign in_n[2] = s_tdata[103:88];
  assign in_v[0] = s_tdata[135:104];
  assign in_v[1] = s_tdata[167:136];
  assign in_v[2] = s_tdata[199:168];

  // stage 1: stiffness product, v*n terms
  logic                    pen_pos;
  logic [30:0]             pen_m;
  logic [62:0]             a_next;
  logic signed [47:0]      vn_next [3];
  logic                    vld1, fr1;
  logic [62:0]             a1;
  logic signed [47:0]      vn1 [3];
  logic signed [NRM_W-1:0] n1 [3];
  logic signed [VEL_W-1:0] v1 [3];
  logic [NODE_W-1:0]       node1;

  assign pen_pos = in_pen > 32'sd0;
  assign pen_m   = pen_pos ? in_pen[30:0] : '0;
  assign a_next  = penalty_factor * pen_m;
  for (genvar d = 0; d < 3; d++) begin : g_vn
    assign vn_next[d] = in_v[d] * in_n[d];
  end

  // stage 2: scale by 1e6, dot product
  logic signed [49:0]      dsum, dbias;
  logic [50:0]             ahi2;
  logic [51:0]             alo2;
  logic signed [35:0]      dot2;
  logic                    vld2, fr2;
  logic signed [NRM_W-1:0] n2 [3];
  logic signed [VEL_W-1:0] v2 [3];
  logic [NODE_W-1:0]       node2;

  assign dsum  = vn1[0] + vn1[1] + vn1[2];
  assign dbias = dsum + (dsum[49] ? 50'sd16383 : 50'sd0);

  // stage 3: normal force magnitude, projection terms
  logic [59:0]             fm_raw;
  logic                    fm_sat;
  logic [FMAG_W-1:0]       fm3;
  logic                    clip3, vld3, fr3;
  logic signed [51:0]      dn3 [3];
  logic signed [NRM_W-1:0] n3 [3];
  logic signed [VEL_W-1:0] v3 [3];
  logic [NODE_W-1:0]       node3;

  assign fm_raw = {ahi2, 8'b0} + 60'(alo2[51:24]);
  assign fm_sat = fm_raw > 60'(FORCE_MAX);

  // stage 4: normal force components, tangential velocity, coulomb limit
  logic signed [FN_W-1:0]  fn_next [3];
  logic signed [VT_W-1:0]  t_next [3];
  logic [62:0]             lim_p;
  logic signed [FN_W-1:0]  fn4 [3];
  logic signed [VT_W-1:0]  t4 [3];
  logic [LIM_W-1:0]        lim4;
  logic                    clip4, vld4, fr4;
  logic [NODE_W-1:0]       node4;

  assign lim_p = friction_coeff * fm3;

  always_comb begin
    logic signed [63:0] fnp, fnb;
    logic signed [51:0] dnb;
    logic signed [37:0] pj;
    logic signed [38:0] diff;
    for (int d = 0; d < 3; d++) begin
      fnp = $signed({1'b0, fm3}) * n3[d];
      fnb = fnp + (fnp[63] ? 64'sd16383 : 64'sd0);
      fn_next[d] = fnb[63:14];
      dnb  = dn3[d] + (dn3[d][51] ? 52'sd16383 : 52'sd0);
      pj   = dnb[51:14];
      diff = v3[d] - pj;
      if (diff > 39'sd2147483647) begin
        t_next[d] = 32'h7FFF_FFFF;
      end else if (diff < -39'sd2147483648) begin
        t_next[d] = 32'h8000_0000;
      end else begin
        t_next[d] = diff[31:0];
      end
    end
  end

  // stage 5: squares
  logic [62:0]             sq_next [3];
  logic [62:0]             sq5 [3];
  logic signed [FN_W-1:0]  fn5 [3];
  logic signed [VT_W-1:0]  t5 [3];
  logic [LIM_W-1:0]        lim5;
  logic                    clip5, vld5, fr5;
  logic [NODE_W-1:0]       node5;

  always_comb begin
    logic signed [63:0] sqp;
    for (int d = 0; d < 3; d++) begin
      sqp = t4[d] * t4[d];
      sq_next[d] = sqp[62:0];
    end
  end

  // stage 6: sum of squares
  logic [SS_W-1:0]         ss6;
  logic signed [FN_W-1:0]  fn6 [3];
  logic signed [VT_W-1:0]  t6 [3];
  logic [LIM_W-1:0]        lim6;
  logic                    clip6, vld6, fr6;
  logic [NODE_W-1:0]       node6;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      vld3 <= 1'b0;
      vld4 <= 1'b0;
      vld5 <= 1'b0;
      vld6 <= 1'b0;
    end else if (adv) begin
      vld1 <= s_tvalid;
      vld2 <= vld1;
      vld3 <= vld2;
      vld4 <= vld3;
      vld5 <= vld4;
      vld6 <= vld5;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a1    <= a_next;
      vn1   <= vn_next;
      n1    <= in_n;
      v1    <= in_v;
      node1 <= in_node;
      fr1   <= pen_pos && friction_enable && (friction_coeff != '0);

      ahi2  <= a1[62:32] * STIFF_SCALE;
      alo2  <= a1[31:0] * STIFF_SCALE;
      dot2  <= dbias[49:14];
      n2    <= n1;
      v2    <= v1;
      node2 <= node1;
      fr2   <= fr1;

      fm3   <= fm_sat ? FORCE_MAX : fm_raw[FMAG_W-1:0];
      clip3 <= fm_sat;
      for (int d = 0; d < 3; d++) dn3[d] <= dot2 * n2[d];
      n3    <= n2;
      v3    <= v2;
      node3 <= node2;
      fr3   <= fr2;

      fn4   <= fn_next;
      t4    <= t_next;
      lim4  <= lim_p[62:12];
      clip4 <= clip3;
      node4 <= node3;
      fr4   <= fr3;

      sq5   <= sq_next;
      fn5   <= fn4;
      t5    <= t4;
      lim5  <= lim4;
      clip5 <= clip4;
      node5 <= node4;
      fr5   <= fr4;

      ss6   <= SS_W'(sq5[0]) + SS_W'(sq5[1]) + SS_W'(sq5[2]);
      fn6   <= fn5;
      t6    <= t5;
      lim6  <= lim5;
      clip6 <= clip5;
      node6 <= node5;
      fr6   <= fr5;
    end
  end

  // tangential speed
  logic [SQ_PW-1:0]        sq_pl_in, sq_pl_out;
  logic                    vldS;
  logic [VM_W-1:0]         vmS;
  logic [NODE_W-1:0]       nodeS;
  logic signed [FN_W-1:0]  fnS [3];
  logic signed [VT_W-1:0]  tS [3];
  logic [LIM_W-1:0]        limS;
  logic                    clipS, frS;

  assign sq_pl_in = {node6, fn6[0], fn6[1], fn6[2], t6[0], t6[1], t6[2], lim6, clip6, fr6};
  assign {nodeS, fnS[0], fnS[1], fnS[2], tS[0], tS[1], tS[2], limS, clipS, frS} = sq_pl_out;

  pcf_sqrt #(
    .PW (SQ_PW)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (vld6),
    .radicand  (ss6),
    .in_pl     (sq_pl_in),
    .out_valid (vldS),
    .root      (vmS),
    .out_pl    (sq_pl_out)
  );

  // stage a: viscous friction products, |vt|
  logic [38:0]             k100;
  logic [VT_W-1:0]         abs_next [3];
  logic                    gt_next [3];
  logic                    vldA, frA, clipA;
  logic [54:0]             phiA, ploA;
  logic [VM_W-1:0]         vmA;
  logic [VT_W-1:0]         absA [3];
  logic                    gtA [3];
  logic signed [FN_W-1:0]  fnA [3];
  logic [LIM_W-1:0]        limA;
  logic [NODE_W-1:0]       nodeA;

  assign k100 = penalty_factor * FRIC_SCALE;
  for (genvar d = 0; d < 3; d++) begin : g_abs
    assign abs_next[d] = tS[d][VT_W-1] ? VT_W'(-tS[d]) : VT_W'(tS[d]);
    assign gt_next[d]  = tS[d] > 32'sd0;
  end

  // stage b: friction magnitude
  logic [55:0]             fv, fmin;
  logic [FMAG_W-1:0]       fmag_next;
  logic                    clipf;
  logic                    vldB, clipB;
  logic [FMAG_W-1:0]       fmagB;
  logic [VT_W-1:0]         absB [3];
  logic [VM_W-1:0]         vmB;
  logic                    gtB [3];
  logic signed [FN_W-1:0]  fnB [3];
  logic [NODE_W-1:0]       nodeB;

  assign fv   = 56'(phiA) + 56'(ploA[54:16]);
  assign fmin = (fv < 56'(limA)) ? fv : 56'(limA);

  always_comb begin
    fmag_next = '0;
    clipf     = 1'b0;
    if (frA) begin
      if (fmin > 56'(FORCE_MAX)) begin
        fmag_next = FORCE_MAX;
        clipf     = 1'b1;
      end else begin
        fmag_next = fmin[FMAG_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vldA <= 1'b0;
      vldB <= 1'b0;
    end else if (adv) begin
      vldA <= vldS;
      vldB <= vldA;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      phiA  <= k100 * vmS[31:16];
      ploA  <= k100 * vmS[15:0];
      vmA   <= vmS;
      absA  <= abs_next;
      gtA   <= gt_next;
      fnA   <= fnS;
      limA  <= limS;
      clipA <= clipS;
      nodeA <= nodeS;
      frA   <= frS && (vmS != '0);

      fmagB <= fmag_next;
      clipB <= clipA || clipf;
      absB  <= absA;
      vmB   <= vmA;
      gtB   <= gtA;
      fnB   <= fnA;
      nodeB <= nodeA;
    end
  end

  // tangent direction
  logic [DV_PW-1:0]        dv_pl_in, dv_pl_out;
  logic                    vldV;
  logic [Q_W-1:0]          qV [3];
  logic [NODE_W-1:0]       nodeV;
  logic signed [FN_W-1:0]  fnV [3];
  logic                    gtV [3];
  logic [FMAG_W-1:0]       fmagV;
  logic                    clipV;

  assign dv_pl_in = {nodeB, fnB[0], fnB[1], fnB[2], gtB[0], gtB[1], gtB[2], fmagB, clipB};
  assign {nodeV, fnV[0], fnV[1], fnV[2], gtV[0], gtV[1], gtV[2], fmagV, clipV} = dv_pl_out;

  pcf_div #(
    .PW (DV_PW)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (vldB),
    .num       (absB),
    .den       (vmB),
    .in_pl     (dv_pl_in),
    .out_valid (vldV),
    .quo       (qV),
    .out_pl    (dv_pl_out)
  );

  // stage c: friction components
  logic signed [FT_W-1:0]  ft_next [3];
  logic                    vldC, clipC;
  logic signed [FT_W-1:0]  ftC [3];
  logic signed [FN_W-1:0]  fnC [3];
  logic [NODE_W-1:0]       nodeC;

  always_comb begin
    logic [61:0]       cp;
    logic [FRC_W-1:0]  c;
    for (int d = 0; d < 3; d++) begin
      cp = fmagV * qV[d];
      c  = cp[61:14];
      ft_next[d] = gtV[d] ? -$signed({1'b0, c}) : $signed({1'b0, c});
    end
  end

  // stage d: sum and saturate into the output register
  logic [FRC_W-1:0]        fo_next [3];
  logic                    clip_sum;
  logic [NODE_W-1:0]       node_o;
  logic [FRC_W-1:0]        fo [3];
  logic                    clip_o;

  always_comb begin
    logic signed [50:0] sum;
    clip_sum = 1'b0;
    for (int d = 0; d < 3; d++) begin
      sum = fnC[d] + ftC[d];
      if (sum[50] && !(&sum[49:47])) begin
        fo_next[d] = {1'b1, {(FRC_W-1){1'b0}}};
        clip_sum   = 1'b1;
      end else if (!sum[50] && (|sum[49:47])) begin
        fo_next[d] = {1'b0, {(FRC_W-1){1'b1}}};
        clip_sum   = 1'b1;
      end else begin
        fo_next[d] = sum[FRC_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vldC     <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      vldC     <= vldV;
      m_tvalid <= vldC;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ftC    <= ft_next;
      fnC    <= fnV;
      clipC  <= clipV;
      nodeC  <= nodeV;

      fo     <= fo_next;
      clip_o <= clipC || clip_sum;
      node_o <= nodeC;
    end
  end

  assign m_tdata = {7'b0, clip_o, fo[2], fo[1], fo[0], NODE_FIELD_W'(node_o)};

endmodule

`default_nettype wire

### design/pcf_chk.sv
`default_nettype none

`include "penalty_contact_force_with_friction_defines.svh"

module pcf_chk (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [pcf_pkg::OUT_W-1:0]       m_tdata,
  input logic                            cfg_valid,
  input logic                            cfg_ready
);

  // a held result keeps its data
  `PCF_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

  // input side follows the output stall only
  `PCF_ASSERT_SAME(a_in_ready, s_tvalid || !s_tvalid, s_tready == (!m_tvalid || m_tready), "s_tready does not track output stall")

  // register writes never wait
  `PCF_ASSERT_SAME(a_cfg_ready, cfg_valid, cfg_ready, "cfg write not taken")

  // nothing leaves right after reset
  `PCF_ASSERT_SAME(a_rst_empty, $past(rst), !m_tvalid, "result valid right after reset")

endmodule

bind penalty_contact_force_with_friction pcf_chk u_chk (.*);

`default_nettype wire
